// ----- rtl/ffa_pkg.sv -----
package ffa_pkg;

    localparam int FREE_ENTRIES = 32;
    localparam int COUNT_BITS   = 24;

    localparam int FIELD_BITS   = 24;
    localparam int MULT_BITS    = 3;
    localparam int STATUS_BITS  = 2;
    localparam int ADDR_BITS    = 4;
    localparam int DATA_BITS    = 32;

    localparam int K_BITS       = $clog2(FREE_ENTRIES);
    localparam int USED_BITS    = $clog2(FREE_ENTRIES + 1);
    localparam int WIDE_BITS    = COUNT_BITS + FIELD_BITS + MULT_BITS;

    localparam logic [FIELD_BITS-1:0] POOL_SIZE_RESET = 24'hFFFFFF;
    localparam logic [MULT_BITS-1:0]  MULT_RESET      = 3'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_FIT    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_LIST_FULL = 2'd2;

    localparam logic [1:0] REG_POOL_SIZE = 2'd0;
    localparam logic [1:0] REG_DYN_MODE  = 2'd1;
    localparam logic [1:0] REG_DYN_MULT  = 2'd2;

    typedef struct packed {
        logic [COUNT_BITS-1:0] offset;
        logic [COUNT_BITS-1:0] size;
    } ffa_entry_t;

    localparam ffa_entry_t ENTRY_RESET = '{offset: '0,
                                           size: COUNT_BITS'(POOL_SIZE_RESET)};

endpackage

// ----- rtl/first_fit_free_list_allocator.sv -----
// First-fit allocator over a list of free blocks held in a ring of cells.
// Input channel: in_valid/in_stall carry opcode (0 allocate, 1 free),
// vertex_count and start_offset. A transaction is taken when in_valid is
// high and in_stall is low. Output channel: out_valid/out_stall carry
// alloc_offset and status (0 ok, 1 no fit, 2 list full), one per input.
// Each transaction rotates the whole list once through the head cell, so
// the head examines one entry per cycle. An allocation that empties an
// entry other than the last one takes a second rotation (S_FILL) to move
// the last entry into the hole. After the rotation the block waits in
// S_EMIT, and the result register loads from there once the output
// register is free; the next transaction is taken in the cycle after the
// result loads. While out_stall holds the result, a new transaction may
// still be taken and worked on; it waits at its end until the output
// register is free. Reset leaves one free block covering the whole pool
// at offset zero and sets the registers to their defaults; no clearing
// pass is needed. Configuration must be written over the APB port only
// while the block is idle; the block itself does not enforce this.
module first_fit_free_list_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ffa_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [ffa_pkg::DATA_BITS-1:0]      pwdata,
    output logic [ffa_pkg::DATA_BITS-1:0]      prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               opcode,
    input  logic [ffa_pkg::FIELD_BITS-1:0]     vertex_count,
    input  logic [ffa_pkg::FIELD_BITS-1:0]     start_offset,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ffa_pkg::FIELD_BITS-1:0]     alloc_offset,
    output logic [ffa_pkg::STATUS_BITS-1:0]    status
);
    import ffa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FILL = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [FIELD_BITS-1:0] pool_size_reg, pool_size_next;
    logic                  dyn_mode_reg, dyn_mode_next;
    logic [MULT_BITS-1:0]  dyn_mult_reg, dyn_mult_next;

    logic [K_BITS-1:0]     k_reg, k_next;
    logic [USED_BITS-1:0]  used_reg, used_next;
    logic                  found_reg, found_next;
    logic                  rm_reg, rm_next;
    logic                  hole_reg, hole_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  op_reg, op_next;
    logic                  big_reg, big_next;
    logic                  full_reg, full_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] start_reg, start_next;
    logic [K_BITS-1:0]     hit_reg, hit_next;
    ffa_entry_t            held_reg, held_next;
    logic [FIELD_BITS-1:0] res_off_reg, res_off_next;
    logic [FIELD_BITS-1:0]  alloc_offset_reg, alloc_offset_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;

    ffa_entry_t cell_q [FREE_ENTRIES];
    ffa_entry_t tail;
    ffa_entry_t head;
    logic       shift;

    logic                  cfg_write;
    logic                  in_accept;
    logic [WIDE_BITS-1:0]  prod;
    logic [USED_BITS-1:0]  k_ext;
    logic                  in_list;
    logic                  last_hit;
    logic                  fits;
    logic                  pass_end;
    logic                  out_free;
    logic [COUNT_BITS-1:0] new_size;
    logic [COUNT_BITS-1:0] new_off;

    genvar gi;
    generate
        for (gi = 0; gi < FREE_ENTRIES; gi++)
        begin : g_cell
            if (gi == FREE_ENTRIES - 1)
            begin : g_tail
                ffa_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (shift),
                    .entry_in  (tail),
                    .entry_out (cell_q[gi])
                );
            end
            else
            begin : g_body
                ffa_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (shift),
                    .entry_in  (cell_q[gi+1]),
                    .entry_out (cell_q[gi])
                );
            end
        end
    endgenerate

    assign head      = cell_q[0];
    assign shift     = (state_reg == S_SCAN) || (state_reg == S_FILL);
    assign cfg_write = psel && penable && pwrite;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign pready    = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_POOL_SIZE: prdata = DATA_BITS'(pool_size_reg);
            REG_DYN_MODE:  prdata = DATA_BITS'(dyn_mode_reg);
            REG_DYN_MULT:  prdata = DATA_BITS'(dyn_mult_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        if (dyn_mode_reg)
        begin
            prod = WIDE_BITS'(vertex_count) * WIDE_BITS'(dyn_mult_reg);
        end
        else
        begin
            prod = WIDE_BITS'(vertex_count);
        end
    end

    assign k_ext    = USED_BITS'(k_reg);
    assign in_list  = (k_ext < used_reg);
    assign last_hit = (k_ext == (used_reg - USED_BITS'(1)));
    assign fits     = (head.size >= cnt_reg);
    assign new_size = head.size - cnt_reg;
    assign new_off  = head.offset + cnt_reg;
    assign pass_end = (k_reg == K_BITS'(FREE_ENTRIES - 1));
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next        = state_reg;
        pool_size_next    = pool_size_reg;
        dyn_mode_next     = dyn_mode_reg;
        dyn_mult_next     = dyn_mult_reg;
        k_next            = k_reg;
        used_next         = used_reg;
        found_next        = found_reg;
        rm_next           = rm_reg;
        hole_next         = hole_reg;
        op_next           = op_reg;
        big_next          = big_reg;
        full_next         = full_reg;
        cnt_next          = cnt_reg;
        start_next        = start_reg;
        hit_next          = hit_reg;
        held_next         = held_reg;
        res_off_next      = res_off_reg;
        alloc_offset_next = alloc_offset_reg;
        status_next       = status_reg;
        out_valid_next    = out_valid_reg && out_stall;
        tail              = head;

        if (cfg_write)
        begin
            case (paddr[3:2])
                REG_POOL_SIZE: pool_size_next = pwdata[FIELD_BITS-1:0];
                REG_DYN_MODE:  dyn_mode_next  = pwdata[0];
                REG_DYN_MULT:  dyn_mult_next  = pwdata[MULT_BITS-1:0];
                default:       pool_size_next = pool_size_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next    = opcode;
                    cnt_next   = prod[COUNT_BITS-1:0];
                    big_next   = |prod[WIDE_BITS-1:COUNT_BITS];
                    start_next = COUNT_BITS'(start_offset);
                    full_next  = (used_reg >= USED_BITS'(FREE_ENTRIES));
                    k_next     = '0;
                    found_next = 1'b0;
                    rm_next    = 1'b0;
                    hole_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (!big_reg && in_list && !found_reg && fits)
                    begin
                        found_next   = 1'b1;
                        hit_next     = k_reg;
                        res_off_next = FIELD_BITS'(head.offset);
                        tail.offset  = new_off;
                        tail.size    = new_size;
                        if (new_size == '0)
                        begin
                            rm_next   = 1'b1;
                            hole_next = !last_hit;
                        end
                    end
                    else if (hole_reg && last_hit)
                    begin
                        held_next = head;
                    end
                end
                else if (!full_reg && (k_ext == used_reg))
                begin
                    tail.offset = start_reg;
                    tail.size   = big_reg ? '1 : cnt_reg;
                end

                k_next = k_reg + K_BITS'(1);
                if (pass_end)
                begin
                    k_next = '0;
                    if (op_reg == OP_ALLOC)
                    begin
                        if (rm_next)
                        begin
                            used_next = used_reg - USED_BITS'(1);
                        end
                    end
                    else if (!full_reg)
                    begin
                        used_next = used_reg + USED_BITS'(1);
                    end
                    state_next = hole_reg ? S_FILL : S_EMIT;
                end
            end
            S_FILL:
            begin
                if (k_reg == hit_reg)
                begin
                    tail = held_reg;
                end
                k_next = k_reg + K_BITS'(1);
                if (pass_end)
                begin
                    k_next     = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (op_reg == OP_FREE)
                    begin
                        alloc_offset_next = '0;
                        status_next       = full_reg ? ST_LIST_FULL : ST_OK;
                    end
                    else if (found_reg)
                    begin
                        alloc_offset_next = res_off_reg;
                        status_next       = ST_OK;
                    end
                    else
                    begin
                        alloc_offset_next = pool_size_reg;
                        status_next       = ST_NO_FIT;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pool_size_reg <= POOL_SIZE_RESET;
            dyn_mode_reg  <= 1'b0;
            dyn_mult_reg  <= MULT_RESET;
            k_reg         <= '0;
            used_reg      <= USED_BITS'(1);
            found_reg     <= 1'b0;
            rm_reg        <= 1'b0;
            hole_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_size_reg <= pool_size_next;
            dyn_mode_reg  <= dyn_mode_next;
            dyn_mult_reg  <= dyn_mult_next;
            k_reg         <= k_next;
            used_reg      <= used_next;
            found_reg     <= found_next;
            rm_reg        <= rm_next;
            hole_reg      <= hole_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        big_reg          <= big_next;
        full_reg         <= full_next;
        cnt_reg          <= cnt_next;
        start_reg        <= start_next;
        hit_reg          <= hit_next;
        held_reg         <= held_next;
        res_off_reg      <= res_off_next;
        alloc_offset_reg <= alloc_offset_next;
        status_reg       <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign alloc_offset = alloc_offset_reg;
    assign status       = status_reg;

endmodule

// ----- rtl/ffa_cell.sv -----
module ffa_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift,
    input  ffa_pkg::ffa_entry_t entry_in,
    output ffa_pkg::ffa_entry_t entry_out
);
    import ffa_pkg::*;

    ffa_entry_t entry_reg;
    ffa_entry_t entry_next;

    // Every cell resets to the initial whole-pool block; only cell 0 counts as listed.
    always_comb
    begin
        entry_next = entry_reg;
        if (shift)
        begin
            entry_next = entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= ENTRY_RESET;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry_out = entry_reg;

endmodule
